/* sv/pnac_pkg.sv */
// Shared constants, codes and types for the path normalize / allowlist check core.
// No dependencies.
package pnac_pkg;

   localparam int PATH_BYTES_DEFAULT = 256;
   localparam int MAX_DEPTH_DEFAULT  = 128;

   localparam logic [7:0] SLASH = 8'h2F;
   localparam logic [7:0] DOT   = 8'h2E;

   localparam logic [63:0] FIRST_PREFIX_RESET  = 64'h0000_0000_7470_6F2F; // "/opt"
   localparam logic [63:0] SECOND_PREFIX_RESET = 64'h0000_0000_706D_742F; // "/tmp"
   localparam logic [3:0]  PREFIX_LENGTH_RESET = 4'd4;

   // Leading bytes of the normalized path kept for the prefix compare
   localparam int HEAD_BYTES = 9;
   typedef logic [HEAD_BYTES-1:0][7:0] head_type;

   localparam logic [1:0] CSR_FIRST_PREFIX         = 2'd0;
   localparam logic [1:0] CSR_FIRST_PREFIX_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_SECOND_PREFIX        = 2'd2;
   localparam logic [1:0] CSR_SECOND_PREFIX_LENGTH = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NOT_ABS  = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   localparam logic [2:0] VERDICT_ALLOWED   = 3'd0;
   localparam logic [2:0] VERDICT_OUTSIDE   = 3'd3;
   localparam logic [2:0] VERDICT_IS_PREFIX = 3'd4;

endpackage

/* sv/pnac_req_if.sv */
// Input channel of the path check core: one path byte per beat.
// Depends on nothing.
interface pnac_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_char;
   logic       last_char;

   modport source (output valid, output path_char, output last_char, input ready);
   modport sink   (input valid, input path_char, input last_char, output ready);
endinterface

/* sv/pnac_rsp_if.sv */
// Result channel of the path check core: one verdict beat per path.
// Depends on nothing.
interface pnac_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] verdict;
   logic [7:0] normalized_length;

   modport source (output valid, output verdict, output normalized_length, input ready);
   modport sink   (input valid, input verdict, input normalized_length, output ready);
endinterface

/* sv/path_normalize_allowlist_check_core.sv */
// Streaming lexical path normalizer with a two-entry directory allowlist.
// Uses pnac_pkg, pnac_req_if and pnac_rsp_if. Takes one path byte per cycle unless the
// result side stalls; the verdict passes the judge stage and then the output register.
// The separator stack memory reads ahead at the next top of stack each cycle.
// Synchronous reset clears the walker state and loads "/opt" and "/tmp".
module path_normalize_allowlist_check_core #(
   parameter int PATH_BYTES = pnac_pkg::PATH_BYTES_DEFAULT,
   parameter int MAX_DEPTH  = pnac_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   pnac_req_if.sink           req_bus,
   pnac_rsp_if.source         rsp_bus,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_write_data
);

   localparam int PW = $clog2(PATH_BYTES);      // write position
   localparam int CW = PW + 1;                  // component length, saturates at PATH_BYTES
   localparam int SW = PW + 2;                  // candidate end position
   localparam int DW = $clog2(MAX_DEPTH + 1);   // stack depth
   localparam int AW = $clog2(MAX_DEPTH);       // stack address
   localparam int HB = pnac_pkg::HEAD_BYTES;

   // configuration
   logic [63:0] first_prefix_ff, second_prefix_ff;
   logic [3:0]  first_len_ff, second_len_ff;

   // walker state
   logic [PW-1:0]       wp_ff, wp_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [CW-1:0]       clen_ff, clen_in;
   logic                dots_ff, dots_in;
   logic [1:0]          err_ff, err_in;
   logic                first_ff, first_in;
   pnac_pkg::head_type  head_ff, head_in;

   // separator stack
   logic [PW-1:0] stack_mem [MAX_DEPTH];
   logic [PW-1:0] top_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [PW-1:0] mem_wd;

   // judge stage and output register
   logic               j_v_ff, j_v_in;
   logic [PW-1:0]      j_wp_ff;
   logic [1:0]         j_err_ff;
   pnac_pkg::head_type j_head_ff;
   logic               out_v_ff, out_v_in;
   logic [2:0]         out_verdict_ff;
   logic [7:0]         out_len_ff;
   logic [2:0]         verdict_c;

   logic               req_go, j_go;
   logic [PW-1:0]      step_wp;
   logic [1:0]         step_err;
   pnac_pkg::head_type step_head;

   assign j_go          = !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = !j_v_ff || j_go;
   assign req_go        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_prefix_ff  <= pnac_pkg::FIRST_PREFIX_RESET;
         first_len_ff     <= pnac_pkg::PREFIX_LENGTH_RESET;
         second_prefix_ff <= pnac_pkg::SECOND_PREFIX_RESET;
         second_len_ff    <= pnac_pkg::PREFIX_LENGTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pnac_pkg::CSR_FIRST_PREFIX:         first_prefix_ff  <= csr_write_data;
            pnac_pkg::CSR_FIRST_PREFIX_LENGTH:  first_len_ff     <= csr_write_data[3:0];
            pnac_pkg::CSR_SECOND_PREFIX:        second_prefix_ff <= csr_write_data;
            pnac_pkg::CSR_SECOND_PREFIX_LENGTH: second_len_ff    <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [PW-1:0]      wp_v;
      logic [DW-1:0]      dp_v;
      logic [CW-1:0]      cl_v;
      logic               dots_v;
      logic [1:0]         err_v;
      pnac_pkg::head_type hd_v;
      logic [SW-1:0]      base_v, pos_v, neww_v;
      logic               fin_v;
      logic [7:0]         c;

      c      = req_bus.path_char;
      wp_v   = wp_ff;
      dp_v   = depth_ff;
      cl_v   = clen_ff;
      dots_v = dots_ff;
      err_v  = err_ff;
      hd_v   = head_ff;
      pos_v  = '0;
      fin_v  = 1'b0;
      mem_we = 1'b0;
      mem_wa = depth_ff[AW-1:0];
      mem_wd = wp_ff;
      first_in = first_ff;

      if (req_go) begin
         if (first_ff) begin
            first_in = 1'b0;
            if (c != pnac_pkg::SLASH) begin
               err_v = pnac_pkg::ERR_NOT_ABS;
            end else begin
               hd_v[0] = pnac_pkg::SLASH;
               wp_v    = PW'(1);
            end
         end else if (err_ff == pnac_pkg::ERR_NONE) begin
            if (c == pnac_pkg::SLASH) begin
               fin_v = 1'b1;
            end else begin
               // component bytes land speculatively; a later pop leaves them above the end
               base_v = SW'(wp_v) + SW'(wp_v > PW'(1));
               pos_v  = base_v + SW'(cl_v);
               for (int k = 0; k < HB; k++) begin
                  if (pos_v == SW'(k)) hd_v[k] = c;
               end
               if (cl_v < CW'(PATH_BYTES)) cl_v = cl_v + CW'(1);
               if (c != pnac_pkg::DOT) dots_v = 1'b0;
            end
         end
         if (req_bus.last_char && err_v == pnac_pkg::ERR_NONE) fin_v = 1'b1;
      end

      base_v = SW'(wp_v) + SW'(wp_v > PW'(1));
      neww_v = base_v + SW'(cl_v);
      if (fin_v) begin
         if (!(cl_v == CW'(0) || (dots_v && cl_v == CW'(1)))) begin
            if (dots_v && cl_v == CW'(2)) begin
               // parent: restore the end position saved when this level was entered
               if (dp_v != DW'(0)) begin
                  dp_v = dp_v - DW'(1);
                  wp_v = top_ff;
               end else begin
                  wp_v = PW'(1);
               end
            end else if (neww_v >= SW'(PATH_BYTES) || dp_v >= DW'(MAX_DEPTH)) begin
               err_v = pnac_pkg::ERR_TOO_LONG;
            end else begin
               mem_we = 1'b1;
               mem_wa = dp_v[AW-1:0];
               mem_wd = wp_v;
               dp_v   = dp_v + DW'(1);
               if (wp_v > PW'(1)) begin
                  for (int k = 0; k < HB; k++) begin
                     if (wp_v == PW'(k)) hd_v[k] = pnac_pkg::SLASH;
                  end
               end
               wp_v = neww_v[PW-1:0];
            end
         end
         cl_v   = CW'(0);
         dots_v = 1'b1;
      end

      step_wp   = wp_v;
      step_err  = err_v;
      step_head = hd_v;
      head_in   = hd_v;

      if (req_go && req_bus.last_char) begin
         wp_in    = PW'(0);
         depth_in = DW'(0);
         clen_in  = CW'(0);
         dots_in  = 1'b1;
         err_in   = pnac_pkg::ERR_NONE;
         first_in = 1'b1;
      end else begin
         wp_in    = wp_v;
         depth_in = dp_v;
         clen_in  = cl_v;
         dots_in  = dots_v;
         err_in   = err_v;
      end
   end

   // read ahead at the top of the next depth
   assign mem_ra = AW'(depth_in - DW'(1));

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_wa == mem_ra) top_ff <= mem_wd;
      else                            top_ff <= stack_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         depth_ff <= '0;
         clen_ff  <= '0;
         dots_ff  <= 1'b1;
         err_ff   <= pnac_pkg::ERR_NONE;
         first_ff <= 1'b1;
      end else begin
         wp_ff    <= wp_in;
         depth_ff <= depth_in;
         clen_ff  <= clen_in;
         dots_ff  <= dots_in;
         err_ff   <= err_in;
         first_ff <= first_in;
      end
      head_ff <= head_in;
   end

   function automatic logic [2:0] match_prefix(input logic [63:0] prefix,
                                               input logic [3:0] plen,
                                               input pnac_pkg::head_type head,
                                               input logic [PW-1:0] wp);
      logic [3:0] n;
      logic       hit;
      logic [7:0] sb;
      logic [7:0] nb;
      logic       more;
      n   = (plen > 4'd8) ? 4'd8 : plen;
      hit = 1'b1;
      for (int i = 0; i < 8; i++) begin
         sb = (PW'(i) < wp) ? head[i] : 8'h00;
         if (4'(i) < n && sb != prefix[8*i +: 8]) hit = 1'b0;
      end
      more = PW'(n) < wp;
      nb   = more ? head[n] : 8'h00;
      if (n == 4'd0 || !hit)                    return pnac_pkg::VERDICT_OUTSIDE;
      else if (more && nb == pnac_pkg::SLASH)   return pnac_pkg::VERDICT_ALLOWED;
      else if (!more)                           return pnac_pkg::VERDICT_IS_PREFIX;
      else                                      return pnac_pkg::VERDICT_OUTSIDE;
   endfunction

   always_comb begin
      logic [2:0] v1;
      v1 = match_prefix(first_prefix_ff, first_len_ff, j_head_ff, j_wp_ff);
      if (j_err_ff != pnac_pkg::ERR_NONE)         verdict_c = 3'(j_err_ff);
      else if (v1 == pnac_pkg::VERDICT_OUTSIDE)
         verdict_c = match_prefix(second_prefix_ff, second_len_ff, j_head_ff, j_wp_ff);
      else                                         verdict_c = v1;
   end

   always_comb begin
      if (req_go && req_bus.last_char) j_v_in = 1'b1;
      else if (j_go)                   j_v_in = 1'b0;
      else                             j_v_in = j_v_ff;
      out_v_in = j_go ? j_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         j_v_ff   <= j_v_in;
         out_v_ff <= out_v_in;
      end
      if (req_go && req_bus.last_char) begin
         j_wp_ff   <= step_wp;
         j_err_ff  <= step_err;
         j_head_ff <= step_head;
      end
      if (j_go && j_v_ff) begin
         out_verdict_ff <= verdict_c;
         out_len_ff     <= (j_err_ff != pnac_pkg::ERR_NONE) ? 8'h00 : 8'(j_wp_ff);
      end
   end

   assign rsp_bus.valid             = out_v_ff;
   assign rsp_bus.verdict           = out_verdict_ff;
   assign rsp_bus.normalized_length = out_len_ff;

endmodule

/* bench/pnac_verdict_checker.sv */
// Checker for the path normalize / allowlist core: watches the request, result and
// register ports, predicts each path verdict and compares it. Uses pnac_pkg and both
// channel interfaces.
`timescale 1ns / 100ps
module pnac_verdict_checker #(
   parameter int PATH_BYTES = pnac_pkg::PATH_BYTES_DEFAULT,
   parameter int MAX_DEPTH  = pnac_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pnac_req_if         req_mon,
   pnac_rsp_if         rsp_mon,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output int          fail_count,
   output int          pending_verdicts,
   output int          verdicts_checked
);

   typedef struct packed {
      logic [2:0] verdict;
      logic [7:0] length;
   } verdict_beat_type;

   verdict_beat_type verdict_q[$];

   // register copies
   logic [63:0] first_pfx, second_pfx;
   logic [3:0]  first_len, second_len;

   // normalizer state
   logic [7:0]  norm_path [PATH_BYTES];
   int unsigned climb_stack [MAX_DEPTH];
   int unsigned wpos, depth, comp_len;
   logic [1:0]  err;
   bit          at_start, only_dots;

   initial begin
      fail_count = 0;
      pending_verdicts = 0;
      verdicts_checked = 0;
   end

   function automatic void restart_path();
      wpos = 0;
      depth = 0;
      comp_len = 0;
      err = pnac_pkg::ERR_NONE;
      at_start = 1'b1;
      only_dots = 1'b1;
   endfunction

   // a component after the root is preceded by its separator
   function automatic int unsigned comp_base();
      return wpos + ((wpos > 1) ? 1 : 0);
   endfunction

   function automatic void close_component();
      int unsigned len, new_w;
      len = comp_len;
      comp_len = 0;
      if (len == 0 || (only_dots && len == 1)) begin
         only_dots = 1'b1;
         return;
      end
      if (only_dots && len == 2) begin
         only_dots = 1'b1;
         if (depth > 0) begin
            depth--;
            wpos = climb_stack[depth];
         end else begin
            wpos = 1;
         end
         return;
      end
      only_dots = 1'b1;
      new_w = comp_base() + len;
      if (new_w >= PATH_BYTES || depth >= MAX_DEPTH) begin
         err = pnac_pkg::ERR_TOO_LONG;
         return;
      end
      climb_stack[depth] = wpos;
      depth++;
      if (wpos > 1) norm_path[wpos] = pnac_pkg::SLASH;
      wpos = new_w;
   endfunction

   // zero past the end of the normalized path
   function automatic logic [7:0] path_byte(int unsigned i);
      return (i < wpos && i < PATH_BYTES) ? norm_path[i] : 8'h00;
   endfunction

   function automatic logic [2:0] prefix_verdict(logic [63:0] pfx, logic [3:0] plen);
      int unsigned n;
      n = plen;
      if (n == 0) return pnac_pkg::VERDICT_OUTSIDE;
      if (n > 8) n = 8;
      for (int unsigned i = 0; i < n; i++) begin
         if (path_byte(i) != pfx[8*i +: 8]) return pnac_pkg::VERDICT_OUTSIDE;
      end
      if (n < wpos && path_byte(n) == pnac_pkg::SLASH) return pnac_pkg::VERDICT_ALLOWED;
      if (n >= wpos) return pnac_pkg::VERDICT_IS_PREFIX;
      return pnac_pkg::VERDICT_OUTSIDE;
   endfunction

   function automatic void take_byte(logic [7:0] c, logic fin);
      int unsigned slot;
      verdict_beat_type res;
      if (at_start) begin
         at_start = 1'b0;
         if (c != pnac_pkg::SLASH) begin
            err = pnac_pkg::ERR_NOT_ABS;
         end else begin
            norm_path[0] = pnac_pkg::SLASH;
            wpos = 1;
         end
      end else if (err == pnac_pkg::ERR_NONE) begin
         if (c == pnac_pkg::SLASH) begin
            close_component();
         end else begin
            slot = comp_base() + comp_len;
            if (slot < PATH_BYTES) norm_path[slot] = c;
            if (comp_len < PATH_BYTES) comp_len++;
            if (c != pnac_pkg::DOT) only_dots = 1'b0;
         end
      end
      if (!fin) return;
      if (err == pnac_pkg::ERR_NONE) close_component();
      if (err != pnac_pkg::ERR_NONE) begin
         // error codes double as verdict codes
         res.verdict = {1'b0, err};
         res.length = '0;
      end else begin
         res.verdict = prefix_verdict(first_pfx, first_len);
         if (res.verdict == pnac_pkg::VERDICT_OUTSIDE)
            res.verdict = prefix_verdict(second_pfx, second_len);
         res.length = 8'(wpos);
      end
      verdict_q.push_back(res);
      restart_path();
   endfunction

   function automatic void note_mismatch(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
   endfunction

   function automatic void check_beat(logic [2:0] v, logic [7:0] len);
      verdict_beat_type want;
      if (verdict_q.size() == 0) begin
         note_mismatch($sformatf("verdict beat with none pending: verdict %0d length %0d",
                                 v, len));
         return;
      end
      want = verdict_q.pop_front();
      verdicts_checked++;
      if (v !== want.verdict || len !== want.length)
         note_mismatch($sformatf("expected verdict %0d length %0d, got verdict %0d length %0d",
                                 want.verdict, want.length, v, len));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         first_pfx = pnac_pkg::FIRST_PREFIX_RESET;
         first_len = pnac_pkg::PREFIX_LENGTH_RESET;
         second_pfx = pnac_pkg::SECOND_PREFIX_RESET;
         second_len = pnac_pkg::PREFIX_LENGTH_RESET;
         restart_path();
         verdict_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pnac_pkg::CSR_FIRST_PREFIX:         first_pfx = csr_write_data;
               pnac_pkg::CSR_FIRST_PREFIX_LENGTH:  first_len = csr_write_data[3:0];
               pnac_pkg::CSR_SECOND_PREFIX:        second_pfx = csr_write_data;
               pnac_pkg::CSR_SECOND_PREFIX_LENGTH: second_len = csr_write_data[3:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.path_char, req_mon.last_char);
         if (rsp_mon.valid && rsp_mon.ready)
            check_beat(rsp_mon.verdict, rsp_mon.normalized_length);
      end
      pending_verdicts = verdict_q.size();
   end

endmodule

/* bench/tb_path_normalize_allowlist_check_core.sv */
// Top of the path normalize / allowlist core bench: clock, reset, path stimulus,
// register phases and the verdict. Uses pnac_pkg, the channel interfaces,
// pnac_verdict_checker and the core.
`timescale 1ns / 100ps
module tb_path_normalize_allowlist_check_core;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = pnac_pkg::CSR_FIRST_PREFIX;
   logic [63:0] csr_write_data = '0;

   pnac_req_if req_bus();
   pnac_rsp_if rsp_bus();

   int fail_count, pending_verdicts, verdicts_checked;
   bit idle_on = 1'b1;
   int hold_request = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int paths_sent = 0;
   int settings_used = 1;
   logic [7:0] path_buf[$];

   always #5 clock = ~clock;

   path_normalize_allowlist_check_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   pnac_verdict_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_verdicts (pending_verdicts),
      .verdicts_checked (verdicts_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** path_normalize_allowlist_check_core: FAILED **");
         $finish;
      end
   end

   // result side: short random stalls, or one long hold when asked
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (idle_on && stall_left == 0 && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
   endfunction

   function automatic logic [63:0] pack_text(string s);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   function automatic string pick_prefix();
      case ($urandom_range(0, 8))
         0: return "/a";
         1: return "/opt";
         2: return "/tmp";
         3: return "/a/b";
         4: return "/ab";
         5: return "/usr/lib";
         6: return "/.";
         7: return "/a/";
         default: return "/tmp/a";
      endcase
   endfunction

   function automatic void add_slashes();
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
         path_buf.push_back(pnac_pkg::SLASH);
   endfunction

   function automatic void add_component();
      case ($urandom_range(0, 9))
         0: add_text(".");
         1: add_text("..");
         2: add_text("...");
         3: add_text("a");
         4: add_text("b");
         5: add_text("opt");
         6: add_text("tmp");
         7: add_text("ab");
         8: add_text(".x");
         default: repeat ($urandom_range(1, 4))
            path_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
      endcase
   endfunction

   function automatic void build_path(string p1, string p2);
      int kind, target;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
         do b = 8'($urandom_range(1, 255)); while (b == pnac_pkg::SLASH);
         path_buf.push_back(b);
         repeat ($urandom_range(0, 5)) path_buf.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 11) begin
         path_buf.push_back(pnac_pkg::SLASH);
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 3))
               0: path_buf.push_back(pnac_pkg::SLASH);
               1: path_buf.push_back(pnac_pkg::DOT);
               default: path_buf.push_back(8'($urandom_range(1, 255)));
            endcase
         end
      end else if (kind < 15) begin
         // around the store size: one huge component or many small ones
         path_buf.push_back(pnac_pkg::SLASH);
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(250, 258))
               path_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
         end else begin
            target = $urandom_range(240, 300);
            while (path_buf.size() < target) begin
               add_component();
               add_slashes();
            end
         end
      end else begin
         case ($urandom_range(0, 3))
            0: add_text(p1);
            1: add_text(p2);
            default: ;
         endcase
         repeat ($urandom_range(0, 5)) begin
            add_slashes();
            add_component();
         end
         if (path_buf.size() == 0 || $urandom_range(0, 3) == 0) add_slashes();
      end
   endfunction

   task automatic send_beat(logic [7:0] c, logic fin);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.path_char <= c;
      req_bus.last_char <= fin;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_path();
      for (int i = 0; i < path_buf.size(); i++) send_beat(path_buf[i], i == path_buf.size() - 1);
      path_buf.delete();
      paths_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_verdicts != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_registers(logic [63:0] first_value, logic [3:0] first_len,
                                  logic [63:0] second_value, logic [3:0] second_len);
      logic [63:0] noise;
      wait_drained();
      noise = {$urandom, $urandom};
      csr_write_enable <= 1'b1;
      csr_index <= pnac_pkg::CSR_FIRST_PREFIX;
      csr_write_data <= first_value;
      @(negedge clock);
      // upper bits of a length write must be ignored
      csr_index <= pnac_pkg::CSR_FIRST_PREFIX_LENGTH;
      csr_write_data <= {noise[63:4], first_len};
      @(negedge clock);
      csr_index <= pnac_pkg::CSR_SECOND_PREFIX;
      csr_write_data <= second_value;
      @(negedge clock);
      csr_index <= pnac_pkg::CSR_SECOND_PREFIX_LENGTH;
      csr_write_data <= {noise[59:0], second_len};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic run_random(int n_bytes, string p1, string p2);
      int first_byte;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < n_bytes) begin
         build_path(p1, p2);
         send_path();
      end
   endtask

   initial begin : stimulus
      string p1, p2;
      int l1, l2;
      req_bus.valid = 1'b0;
      req_bus.path_char = '0;
      req_bus.last_char = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed paths under the reset allowlist
      add_text("/");
      send_path();
      path_buf.push_back(8'hFF);
      add_text("/o");
      send_path();
      add_text("//opt/");
      send_path();
      add_text("/tmp/./");
      path_buf.push_back(8'h00);
      send_path();
      add_text("/x/..");
      send_path();
      add_text("/..");
      send_path();

      // root-only prefix, all-ones prefix; long result hold with one-byte paths
      write_registers(pack_text("/"), 4'd1, '1, 4'd8);
      hold_request = LONG_HOLD;
      repeat (40) begin
         add_text("/");
         send_path();
      end
      wait_drained();
      run_random(400, "/", "/opt");

      // zero length never matches, oversize length acts as eight
      write_registers('0, 4'd0, pack_text("/usr/lib"), 4'd15);
      run_random(350, "/usr/lib", "/usr");

      repeat (2) begin
         p1 = pick_prefix();
         p2 = pick_prefix();
         l1 = p1.len() + (($urandom_range(0, 3) == 0) ? 1 : 0);
         l2 = p2.len() + (($urandom_range(0, 3) == 0) ? 1 : 0);
         if (l1 > 8) l1 = 8;
         if (l2 > 8) l2 = 8;
         write_registers(pack_text(p1), 4'(l1), pack_text(p2), 4'(l2));
         run_random(350, p1, p2);
      end

      write_registers(pack_text("/a"), 4'd2, pack_text("/tmp"), 4'd4);
      idle_on = 1'b0;
      run_random(450, "/a", "/tmp");

      wait_drained();
      repeat (12) @(negedge clock);
      $display("Sent %0d path bytes in %0d paths under %0d register settings.",
               bytes_sent, paths_sent, settings_used);
      $display("Checked %0d verdicts: root, dot runs, overflow, not absolute, prefix edges.",
               verdicts_checked);
      if (fail_count == 0) begin
         $display("** path_normalize_allowlist_check_core: PASSED **");
      end else begin
         $display("** path_normalize_allowlist_check_core: FAILED **");
      end
      $finish;
   end

endmodule
